@@ hw/rtl/rdt_pkg.sv @@
// Package for the rotation derivative tensor core: widths, kinds, op codes
// and the saturating fixed-point helpers. No dependencies.
`default_nettype none
package rdt_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int Dim       = 3;

  typedef logic signed [DataWidth-1:0] word_t;

  localparam logic [1:0] KindLoadR = 2'd0;
  localparam logic [1:0] KindLoadU = 2'd1;
  localparam logic [1:0] KindComp  = 2'd2;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;

  localparam word_t WMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam word_t WMin = {1'b1, {(DataWidth-1){1'b0}}};

  function automatic word_t sat_wide(input logic signed [DataWidth:0] x);
    if (x > $signed({1'b0, WMax})) sat_wide = WMax;
    else if (x < $signed({1'b1, WMin})) sat_wide = WMin;
    else sat_wide = x[DataWidth-1:0];
  endfunction

  function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] c);
    idx = 4'(r) * 4'd3 + 4'(c);
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/rdt_alu.sv @@
// Shared saturating add / subtract / rounded multiply unit, registered result.
// Depends on rdt_pkg.
`default_nettype none
module rdt_alu (
  input  wire               clk,
  input  wire         [2:0] op,
  input  rdt_pkg::word_t    a,
  input  rdt_pkg::word_t    b,
  output rdt_pkg::word_t    y_r
);
  localparam int W = rdt_pkg::DataWidth;
  localparam int F = rdt_pkg::FracBits;
  logic [W-1:0] ma, mb;
  logic [2*W-1:0] prod, rnd;
  logic [2*W-F-1:0] sh;
  logic neg;
  rdt_pkg::word_t y_nxt, msat;

  always_comb begin
    ma = a[W-1] ? W'(-a) : W'(a);
    mb = b[W-1] ? W'(-b) : W'(b);
    prod = ma * mb;
    rnd = prod + ((2*W)'(1) << (F-1));
    sh = rnd[2*W-1:F];
    neg = a[W-1] ^ b[W-1];
    if (neg) begin
      if (sh > (2*W-F)'({1'b1, {(W-1){1'b0}}})) msat = rdt_pkg::WMin;
      else msat = W'(-sh);
    end else begin
      if (sh > (2*W-F)'(rdt_pkg::WMax)) msat = rdt_pkg::WMax;
      else msat = W'(sh);
    end
    case (op)
      rdt_pkg::OpAdd: y_nxt = rdt_pkg::sat_wide((W+1)'(a) + (W+1)'(b));
      rdt_pkg::OpSub: y_nxt = rdt_pkg::sat_wide((W+1)'(a) - (W+1)'(b));
      default:        y_nxt = msat;
    endcase
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end
endmodule
`default_nettype wire

@@ hw/rtl/rdt_div.sv @@
// Bit-serial restoring divider: (a << FracBits) / b, rounded half away, saturated.
// Depends on rdt_pkg.
`default_nettype none
module rdt_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  rdt_pkg::word_t    a,
  input  rdt_pkg::word_t    b,
  output logic              done_r,
  output rdt_pkg::word_t    q_out
);
  localparam int W = rdt_pkg::DataWidth;
  localparam int F = rdt_pkg::FracBits;
  localparam int NW = W + F;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] num_r, q_r;
  logic [W:0] rem_r, rtry;
  logic [W-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic busy_r, neg_r;
  logic [NW:0] qr;
  logic [W:0] remsh;

  always_comb begin
    remsh = {rem_r[W-1:0], num_r[NW-1]};
    rtry = remsh - (W+1)'(den_r);
    qr = (NW+1)'(q_r) + (NW+1)'((W+1)'(rem_r) >= (W+1)'(den_r) - (W+1)'(rem_r));
    if (neg_r) begin
      if (qr > (NW+1)'({1'b1, {(W-1){1'b0}}})) q_out = rdt_pkg::WMin;
      else q_out = W'(-qr);
    end else begin
      if (qr > (NW+1)'(rdt_pkg::WMax)) q_out = rdt_pkg::WMax;
      else q_out = W'(qr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(NW);
        num_r <= {(a[W-1] ? W'(-a) : W'(a)), {F{1'b0}}};
        den_r <= b[W-1] ? W'(-b) : W'(b);
        neg_r <= a[W-1] ^ b[W-1];
        rem_r <= '0;
        q_r <= '0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        if (!rtry[W]) begin
          rem_r <= rtry;
          q_r <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= remsh;
          q_r <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rotation_derivative_tensor_core.sv @@
// Rotation derivative tensor core: matrix stores, sequencer, shared ALU, divider.
// Depends on rdt_pkg, rdt_alu, rdt_div.
//
// Usage: in_kind 0 loads R(in_row,in_col) from in_value, 1 loads U, 2 computes
// the 3x3 block dR(k,l)/dF with k=in_row, l=in_col. Beats use valid/stall.
// A load is written while idle. A compute holds in_stall high until its last
// beat is taken; nine out_ beats, m outer and n inner, out_last on the ninth.
// Sequence: trace, Uhat and det first run on the shared ALU (25 ops), then
// each result sums nine summands on the ALU, starts the divider, waits for
// the bit-serial divide and is presented in the output register. A zero
// determinant skips the sums and the divide, so its nine beats follow the
// precompute one per cycle while out_stall is low.
// A result waits in the output register while out_stall is high; the next
// entry is not started until it is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle; the matrix
// stores are not cleared and read as unknown until written.
`default_nettype none
module rotation_derivative_tensor_core (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire         [1:0] in_kind,
  input  wire         [1:0] in_row,
  input  wire         [1:0] in_col,
  input  wire signed [31:0] in_value,
  output logic              out_valid,
  input  wire               out_stall,
  output logic        [1:0] out_m,
  output logic        [1:0] out_n,
  output logic signed [31:0] out_deriv_value,
  output logic              out_last,
  output logic              out_det_zero
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_PRE = 6'b000010, S_SUM = 6'b000100,
    S_DIV = 6'b001000, S_OUT = 6'b010000, S_DIVW = 6'b100000
  } state_t;

  state_t state_r;
  rdt_pkg::word_t rs [9];
  rdt_pkg::word_t us [9];
  rdt_pkg::word_t uh_r [9];
  rdt_pkg::word_t tmp_r [4];
  rdt_pkg::word_t acc_r, det_r;
  logic [1:0] k_r, l_r, m_r, n_r, p_r, q_r;
  logic [5:0] step_r;
  logic [3:0] sub_r;
  logic [2:0] op;
  rdt_pkg::word_t a, b, y;
  logic dz_r, div_start, div_done;
  rdt_pkg::word_t div_q;

  rdt_alu u_alu (.clk(clk), .op(op), .a(a), .b(b), .y_r(y));
  rdt_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .a(acc_r), .b(det_r),
                 .done_r(div_done), .q_out(div_q));

  assign in_stall = (state_r != S_IDLE);

  // Precompute: steps 0..1 trace, 2..10 uh = sat(tr*I - U) by subs; det ops.
  // Each op issues at even sub, result captured next cycle (odd sub).
  always_comb begin
    op = rdt_pkg::OpMul;
    a = '0;
    b = '0;
    div_start = (state_r == S_DIV);
    if (state_r == S_PRE) begin
      unique case (step_r)
        6'd0: begin op = rdt_pkg::OpAdd; a = us[0]; b = us[4]; end
        6'd1: begin op = rdt_pkg::OpAdd; a = tmp_r[0]; b = us[8]; end
        6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10: begin
          op = rdt_pkg::OpSub;
          a = ((step_r == 6'd2) || (step_r == 6'd6) || (step_r == 6'd10)) ? tmp_r[1] : '0;
          b = us[4'(step_r - 6'd2)];
        end
        6'd11: begin a = uh_r[4]; b = uh_r[8]; end
        6'd12: begin a = uh_r[5]; b = uh_r[7]; end
        6'd13: begin op = rdt_pkg::OpSub; a = tmp_r[0]; b = tmp_r[1]; end
        6'd14: begin a = uh_r[0]; b = tmp_r[2]; end
        6'd15: begin a = uh_r[3]; b = uh_r[8]; end
        6'd16: begin a = uh_r[5]; b = uh_r[6]; end
        6'd17: begin op = rdt_pkg::OpSub; a = tmp_r[0]; b = tmp_r[1]; end
        6'd18: begin a = uh_r[1]; b = tmp_r[2]; end
        6'd19: begin op = rdt_pkg::OpSub; a = tmp_r[3]; b = tmp_r[0]; end
        6'd20: begin a = uh_r[3]; b = uh_r[7]; end
        6'd21: begin a = uh_r[4]; b = uh_r[6]; end
        6'd22: begin op = rdt_pkg::OpSub; a = tmp_r[0]; b = tmp_r[1]; end
        6'd23: begin a = uh_r[2]; b = tmp_r[2]; end
        default: begin op = rdt_pkg::OpAdd; a = tmp_r[3]; b = tmp_r[0]; end
      endcase
    end else if (state_r == S_SUM) begin
      case (sub_r)
        4'd0: begin a = uh_r[rdt_pkg::idx(p_r, q_r)]; b = rs[rdt_pkg::idx(m_r, q_r)]; end
        4'd1: begin a = y; b = uh_r[rdt_pkg::idx(n_r, l_r)]; end
        4'd2: begin a = uh_r[rdt_pkg::idx(p_r, n_r)]; b = rs[rdt_pkg::idx(m_r, q_r)]; end
        4'd3: begin a = y; b = uh_r[rdt_pkg::idx(q_r, l_r)]; end
        4'd4: begin op = rdt_pkg::OpSub; a = tmp_r[0]; b = y; end
        4'd5: begin a = rs[rdt_pkg::idx(k_r, p_r)]; b = y; end
        default: begin op = rdt_pkg::OpAdd; a = acc_r; b = y; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_row != 2'd3 && in_col != 2'd3) begin
            if (in_kind == rdt_pkg::KindLoadR) rs[rdt_pkg::idx(in_row, in_col)] <= in_value;
            else if (in_kind == rdt_pkg::KindLoadU)
              us[rdt_pkg::idx(in_row, in_col)] <= in_value;
            else if (in_kind == rdt_pkg::KindComp) begin
              k_r <= in_row;
              l_r <= in_col;
              step_r <= '0;
              sub_r <= '0;
              state_r <= S_PRE;
            end
          end
        end
        S_PRE: begin
          // sub 0 issue, sub 1 capture
          if (sub_r == 4'd0) sub_r <= 4'd1;
          else begin
            sub_r <= 4'd0;
            step_r <= step_r + 6'd1;
            unique case (step_r)
              6'd0: tmp_r[0] <= y;
              6'd1: tmp_r[1] <= y;
              6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10:
                uh_r[4'(step_r - 6'd2)] <= y;
              6'd11, 6'd15, 6'd18, 6'd20, 6'd23: tmp_r[0] <= y;
              6'd12, 6'd16, 6'd21: tmp_r[1] <= y;
              6'd13, 6'd17, 6'd22: tmp_r[2] <= y;
              6'd14, 6'd19: tmp_r[3] <= y;
              default: begin
                det_r <= y;
                dz_r <= (y == '0);
                m_r <= '0;
                n_r <= '0;
                p_r <= '0;
                q_r <= '0;
                acc_r <= '0;
                state_r <= (y == '0) ? S_OUT : S_SUM;
                if (y == '0) begin
                  out_valid <= 1'b1;
                  out_m <= '0;
                  out_n <= '0;
                  out_deriv_value <= '0;
                  out_last <= 1'b0;
                  out_det_zero <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SUM: begin
          // every subcycle issues an op; results captured at subs 1, 2 and 7
          sub_r <= sub_r + 4'd1;
          if (sub_r == 4'd1) tmp_r[1] <= y;
          if (sub_r == 4'd2) tmp_r[0] <= y;
          if (sub_r == 4'd6) begin
            sub_r <= 4'd7;
          end
          if (sub_r == 4'd7) begin
            acc_r <= y;
            sub_r <= 4'd0;
            q_r <= (q_r == 2'd2) ? 2'd0 : q_r + 2'd1;
            if (q_r == 2'd2) begin
              p_r <= p_r + 2'd1;
              if (p_r == 2'd2) begin
                p_r <= '0;
                state_r <= S_DIV;
              end
            end
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            out_valid <= 1'b1;
            out_m <= m_r;
            out_n <= n_r;
            out_deriv_value <= div_q;
            out_last <= (m_r == 2'd2) && (n_r == 2'd2);
            out_det_zero <= 1'b0;
            state_r <= S_OUT;
          end
        end
        default: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (m_r == 2'd2 && n_r == 2'd2) state_r <= S_IDLE;
            else begin
              if (n_r == 2'd2) begin
                n_r <= '0;
                m_r <= m_r + 2'd1;
              end else n_r <= n_r + 2'd1;
              acc_r <= '0;
              if (dz_r) begin
                out_valid <= 1'b1;
                out_m <= (n_r == 2'd2) ? m_r + 2'd1 : m_r;
                out_n <= (n_r == 2'd2) ? 2'd0 : n_r + 2'd1;
                out_deriv_value <= '0;
                out_last <= (m_r == 2'd2) && (n_r == 2'd1);
                out_det_zero <= 1'b1;
              end else state_r <= S_SUM;
            end
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire
